/* design/jmvs_pkg.sv */
// Package for the joint motion variance segmenter.
// Field widths, op codes and sequencer states; no dependencies.
`timescale 1ns / 1ps
package jmvs_pkg;

  localparam int POS_W  = 24;
  localparam int SEQ_W  = 32;
  localparam int JNUM_W = 4;
  localparam int VAR_W  = 48;
  localparam logic [VAR_W-1:0] MIN_VAR_RESET = 48'd3298535;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REC,
    ST_FILL,
    ST_RD_WIN,
    ST_SQ_ACC,
    ST_MUL,
    ST_CMP,
    ST_FL_RD,
    ST_FL_EM
  } state_e;

endpackage

/* design/jmvs_if.sv */
// Channel interfaces: sample/flush input, segment output, threshold write.
// Depends on jmvs_pkg for field widths.
`timescale 1ns / 1ps
interface jmvs_in_if import jmvs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [SEQ_W-1:0]        seq;
  logic [JNUM_W-1:0]       joint;
  logic signed [POS_W-1:0] position;
  modport source (output valid, op, seq, joint, position, input ready);
  modport sink   (input valid, op, seq, joint, position, output ready);
endinterface

interface jmvs_out_if import jmvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [JNUM_W-1:0] seg_joint;
  logic [SEQ_W-1:0]  begin_seq;
  logic [SEQ_W-1:0]  end_seq;
  logic              was_moving;
  logic              last;
  modport source (output valid, seg_joint, begin_seq, end_seq, was_moving, last,
                  input ready);
  modport sink   (input valid, seg_joint, begin_seq, end_seq, was_moving, last,
                  output ready);
endinterface

interface jmvs_cfg_if import jmvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/joint_motion_variance_segmenter.sv */
// Top level: per-joint sliding window variance, segment tracking and flush walk.
// Depends on jmvs_pkg, jmvs_if and jmvs_ram.
//
//  channel | dir | beat carries
//  in_i    | in  | op, seq, joint, position
//  out_o   | out | seg_joint, begin_seq, end_seq, was_moving, last
//  cfg_i   | in  | min_variance
//
// A sample of a started joint steps through accept, record read, window read,
// square sum, multiply and compare/write-back; a joint's first sample instead
// runs the window fill sweep, writing its position to all its window RAM words.
// Flush emits started joints of 0..min(JOINTS,16)-1; out-of-range samples drop.
// Reset clears the started bits; no RAM clearing. A busy output stalls the
// sequencer only at the emitting step.
`timescale 1ns / 1ps
module joint_motion_variance_segmenter import jmvs_pkg::*; #(
  parameter int WINDOW = 16,
  parameter int JOINTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  jmvs_in_if.sink    in_i,
  jmvs_out_if.source out_o,
  jmvs_cfg_if.sink   cfg_i
);

  localparam int LW  = $clog2(WINDOW);
  localparam int PW  = LW;
  localparam int SW  = POS_W + LW;
  localparam int PPW = 2 * POS_W - 1;
  localparam int QW  = PPW + LW;
  localparam int WQW = QW + LW;
  localparam int SSW = 2 * SW;
  localparam int THW = VAR_W + 2 * LW;
  localparam int CW  = VAR_W + 2 * LW + 1;
  localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int ACT = (JOINTS < 16) ? JOINTS : 16;
  localparam int AW  = $clog2(JOINTS * WINDOW);

  typedef struct packed {
    logic [PW-1:0]        ptr;
    logic signed [SW-1:0] sum;
    logic [QW-1:0]        sq;
    logic                 moving;
    logic [SEQ_W-1:0]     bseq;
    logic [SEQ_W-1:0]     eseq;
  } rec_t;

  localparam int RW = $bits(rec_t);

  state_e state_q, state_d;

  logic [SEQ_W-1:0]        seq_q;
  logic [JW-1:0]           jidx_q;
  logic signed [POS_W-1:0] p_q;
  logic [PW-1:0]           fill_q;
  logic [JW-1:0]           fidx_q;
  logic [PPW-1:0]          pp_q, oo_q;
  logic signed [SW-1:0]    sum_n_q;
  logic [QW-1:0]           sq_n_q;
  logic [WQW-1:0]          wq_q;
  logic [SSW-1:0]          ss_q;
  logic [VAR_W-1:0]        minvar_q;
  logic [THW-1:0]          thr_q;
  logic [JOINTS-1:0]       started_q;

  logic              out_valid_q;
  logic [JNUM_W-1:0] out_joint_q;
  logic [SEQ_W-1:0]  out_bseq_q, out_eseq_q;
  logic              out_mov_q, out_last_q;

  // ram ports
  logic          rec_re, rec_we;
  logic [JW-1:0] rec_raddr;
  rec_t          rec_rd, rec_wd;
  logic [RW-1:0] rec_rdata;
  logic          win_re, win_we;
  logic [AW-1:0] win_raddr, win_waddr;
  logic [POS_W-1:0] win_rdata;

  logic              in_accept, out_free, emit, emit_last, mv, hi_any;
  logic [JNUM_W-1:0] emit_joint;
  logic              fill_done, set_started, clr_started;
  logic signed [POS_W-1:0]   old_s;
  logic signed [2*POS_W-1:0] pp_full, oo_full;
  logic signed [SSW-1:0]     ss_full;

  assign rec_rd    = rec_t'(rec_rdata);
  assign in_accept = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign old_s     = $signed(win_rdata);
  assign pp_full   = p_q * p_q;
  assign oo_full   = old_s * old_s;
  assign ss_full   = sum_n_q * sum_n_q;
  assign mv        = CW'(wq_q) >= (CW'(ss_q) + CW'(thr_q));
  assign fill_done = (fill_q == PW'(WINDOW - 1));

  function automatic logic [AW-1:0] waddr(input logic [JW-1:0] j, input logic [PW-1:0] k);
    waddr = AW'(j) * AW'(WINDOW) + AW'(k);
  endfunction

  // any started joint above the flush index
  always_comb begin
    hi_any = 1'b0;
    for (int k = 0; k < JOINTS; k++) begin
      if (k < ACT && k > int'(fidx_q) && started_q[k]) begin
        hi_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    rec_re      = 1'b0;
    rec_raddr   = jidx_q;
    rec_we      = 1'b0;
    rec_wd      = rec_rd;
    win_re      = 1'b0;
    win_raddr   = waddr(jidx_q, rec_rd.ptr);
    win_we      = 1'b0;
    win_waddr   = waddr(jidx_q, rec_rd.ptr);
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_joint  = JNUM_W'(jidx_q);
    set_started = 1'b0;
    clr_started = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.op == OP_FLUSH) begin
            state_d = ST_FL_RD;
          end else if (int'(in_i.joint) < JOINTS) begin
            rec_re    = 1'b1;
            rec_raddr = JW'(in_i.joint);
            state_d   = ST_RD_REC;
          end
        end
      end
      ST_RD_REC: begin
        if (!started_q[jidx_q]) begin
          state_d = ST_FILL;
        end else begin
          win_re  = 1'b1;
          state_d = ST_RD_WIN;
        end
      end
      ST_FILL: begin
        win_we    = 1'b1;
        win_waddr = waddr(jidx_q, fill_q);
        if (fill_done) begin
          rec_we        = 1'b1;
          rec_wd.ptr    = '0;
          rec_wd.sum    = SW'(p_q) * SW'(WINDOW);
          rec_wd.sq     = QW'(pp_q) * QW'(WINDOW);
          rec_wd.moving = 1'b0;
          rec_wd.bseq   = seq_q;
          rec_wd.eseq   = seq_q;
          set_started   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_RD_WIN: begin
        win_we  = 1'b1;
        state_d = ST_SQ_ACC;
      end
      ST_SQ_ACC: state_d = ST_MUL;
      ST_MUL:    state_d = ST_CMP;
      ST_CMP: begin
        rec_wd.ptr    = (rec_rd.ptr == PW'(WINDOW - 1)) ? '0 : rec_rd.ptr + 1'b1;
        rec_wd.sum    = sum_n_q;
        rec_wd.sq     = sq_n_q;
        rec_wd.moving = mv;
        rec_wd.eseq   = seq_q;
        if (mv != rec_rd.moving) begin
          rec_wd.bseq = seq_q;
          if (out_free) begin
            emit    = 1'b1;
            rec_we  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          rec_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        rec_re    = 1'b1;
        rec_raddr = fidx_q;
        state_d   = ST_FL_EM;
      end
      ST_FL_EM: begin
        emit_joint = JNUM_W'(fidx_q);
        emit_last  = !hi_any;
        if (!started_q[fidx_q] || out_free) begin
          emit        = started_q[fidx_q];
          clr_started = started_q[fidx_q];
          state_d     = (fidx_q == JW'(ACT - 1)) ? ST_IDLE : ST_FL_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= '0;
      out_valid_q <= 1'b0;
      minvar_q    <= MIN_VAR_RESET;
      fill_q      <= '0;
      fidx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        minvar_q <= cfg_i.data;
      end
      if (set_started) begin
        started_q[jidx_q] <= 1'b1;
      end
      if (clr_started) begin
        started_q[fidx_q] <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_FILL) begin
        fill_q <= fill_done ? '0 : fill_q + 1'b1;
      end
      if (in_accept) begin
        fidx_q <= '0;
      end else if (state_q == ST_FL_EM && state_d == ST_FL_RD) begin
        fidx_q <= fidx_q + 1'b1;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seq_q  <= in_i.seq;
      jidx_q <= JW'(in_i.joint);
      p_q    <= in_i.position;
    end
    pp_q  <= pp_full[PPW-1:0];
    thr_q <= THW'(minvar_q) * THW'(WINDOW * WINDOW);
    if (state_q == ST_RD_WIN) begin
      oo_q    <= oo_full[PPW-1:0];
      sum_n_q <= rec_rd.sum + SW'(p_q) - SW'(old_s);
    end
    if (state_q == ST_SQ_ACC) begin
      sq_n_q <= rec_rd.sq + QW'(pp_q) - QW'(oo_q);
    end
    if (state_q == ST_MUL) begin
      wq_q <= WQW'(sq_n_q) * WQW'(WINDOW);
      ss_q <= ss_full[SSW-1:0];
    end
    if (emit) begin
      out_joint_q <= emit_joint;
      out_bseq_q  <= rec_rd.bseq;
      out_eseq_q  <= rec_rd.eseq;
      out_mov_q   <= rec_rd.moving;
      out_last_q  <= emit_last;
    end
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.seg_joint  = out_joint_q;
  assign out_o.begin_seq  = out_bseq_q;
  assign out_o.end_seq    = out_eseq_q;
  assign out_o.was_moving = out_mov_q;
  assign out_o.last       = out_last_q;

  jmvs_ram #(.WIDTH(RW), .DEPTH(JOINTS), .AW(JW)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (jidx_q),
    .wdata_i (RW'(rec_wd)),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  jmvs_ram #(.WIDTH(POS_W), .DEPTH(JOINTS * WINDOW), .AW(AW)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (p_q),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

endmodule

/* design/jmvs_ram.sv */
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module jmvs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
